>>> hw/rtl/glm_pkg.sv
// ----------------------------------------------------------------------------
// glm_pkg
// shared types and constants of the gradient map color lookup
// ----------------------------------------------------------------------------
package glm_pkg;

    localparam int LEVEL_W     = 8;
    localparam int POS_W       = 16;
    localparam int CHAN_W      = 8;
    localparam int NUM_CH      = 3;
    localparam int STOP_W      = 40;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP0 = 3'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;
    localparam logic [STOP_W-1:0]  STOP1_RESET = 40'hFF_FFFF_FFFF;

    localparam int PROD_W     = CHAN_W + POS_W;
    localparam int DIVIDEND_W = PROD_W + 1;
    localparam int DIVISOR_W  = POS_W + 1;
    localparam int DIV_STAGES = CHAN_W;
    // operand stage, product stage, dividend stage and one stage per quotient bit
    localparam int BACK_STAGES = DIV_STAGES + 3;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;

    // index 2 red, 1 green, 0 blue: matches the stop packing
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        rgb_t             ca;
        rgb_t             cb;
        logic [POS_W-1:0] d;
        logic [POS_W-1:0] span;
    } seg_t;

    typedef struct packed {
        logic [NUM_CH-1:0][DIVIDEND_W-1:0] rem;
        rgb_t                              q;
        logic [DIVISOR_W-1:0]              dvs;
        rgb_t                              ca;
        logic                              zero;
    } div_t;

endpackage

>>> hw/rtl/gradient_map_color_lookup.sv
// ----------------------------------------------------------------------------
// gradient_map_color_lookup
// maps a luminance level to an rgb color along a gradient of 2 to 7 stops
// ----------------------------------------------------------------------------
//  port group         dir  handshake          word
//  level              in   push / full        8-bit luminance
//  red/green/blue_out out  empty / pop        mapped color, 8 bits a channel
//  wr_index/wr_data   in   wr_en              stop_count (0), stop_0..6 (1..7)
//
//  one word per clock sustained while results are popped as they arrive
//  path: segment queue, operand, product, dividend, 8 quotient-bit stages, result queue
//  reset loads a black-to-white gradient of two stops and empties both queues
//  back end issues while in-flight plus waiting results stay under 16
//  full rises once the 4-word segment queue is filled
// ----------------------------------------------------------------------------
module gradient_map_color_lookup #(
    parameter int MAX_STOPS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [glm_pkg::LEVEL_W-1:0]       level,
    output logic                              empty,
    input  logic                              pop,
    output logic [glm_pkg::CHAN_W-1:0]        red_out,
    output logic [glm_pkg::CHAN_W-1:0]        green_out,
    output logic [glm_pkg::CHAN_W-1:0]        blue_out,
    input  logic                              wr_en,
    input  logic [glm_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [glm_pkg::CFG_DATA_W-1:0]    wr_data
);

    localparam int SEG_W = $bits(glm_pkg::seg_t);
    localparam int RGB_W = $bits(glm_pkg::rgb_t);

    glm_pkg::seg_t                                   front_seg;
    logic [SEG_W-1:0]                                mid_head;
    logic [$clog2(glm_pkg::MID_DEPTH+1)-1:0]         mid_count;
    logic                                            mid_empty;
    logic                                            seg_pop;
    logic [$clog2(glm_pkg::OUT_DEPTH+1)-1:0]         out_count;
    logic                                            out_full;
    logic                                            res_valid;
    glm_pkg::rgb_t                                   res;
    logic [RGB_W-1:0]                                out_head;
    glm_pkg::rgb_t                                   out_rgb;

    glm_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .level    (level),
        .seg      (front_seg)
    );

    glm_fifo #(
        .WIDTH (SEG_W),
        .DEPTH (glm_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_seg),
        .pop   (seg_pop),
        .rdata (mid_head),
        .count (mid_count),
        .full  (full),
        .empty (mid_empty)
    );

    glm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (glm_pkg::seg_t'(mid_head)),
        .seg_valid (!mid_empty && (mid_count != '0)),
        .seg_pop   (seg_pop),
        .out_count (out_count),
        .res_valid (res_valid),
        .res       (res)
    );

    glm_fifo #(
        .WIDTH (RGB_W),
        .DEPTH (glm_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .pop   (pop),
        .rdata (out_head),
        .count (out_count),
        .full  (out_full),
        .empty (empty)
    );

    assign out_rgb   = glm_pkg::rgb_t'(out_head);
    assign red_out   = out_rgb[2];
    assign green_out = out_rgb[1];
    assign blue_out  = out_rgb[0];

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result word lost on a full queue");

endmodule

>>> hw/rtl/glm_fifo.sv
// ----------------------------------------------------------------------------
// glm_fifo
// small register queue, power-of-two depth, head word shown while not empty
// ----------------------------------------------------------------------------
module glm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       full,
    output logic                       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hw/rtl/glm_front.sv
// ----------------------------------------------------------------------------
// glm_front
// stop registers and segment classification of each incoming level
// ----------------------------------------------------------------------------
module glm_front #(
    parameter int MAX_STOPS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [glm_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [glm_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic [glm_pkg::LEVEL_W-1:0]       level,
    output glm_pkg::seg_t                     seg
);

    localparam int CW = glm_pkg::COUNT_W;
    localparam int PW = glm_pkg::POS_W;

    logic [CW-1:0]                  count_reg;
    logic [glm_pkg::STOP_W-1:0]     stop_reg [MAX_STOPS];
    logic [CW-1:0]                  n_eff;
    logic [PW-1:0]                  pos;
    logic [PW-1:0]                  p [MAX_STOPS];
    glm_pkg::rgb_t                  col [MAX_STOPS];
    logic [PW-1:0]                  last_pos;
    glm_pkg::rgb_t                  last_col;
    logic                           found;
    logic [PW-1:0]                  sel_pa;
    logic [PW-1:0]                  sel_pb;
    glm_pkg::rgb_t                  sel_a;
    glm_pkg::rgb_t                  sel_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= glm_pkg::COUNT_RESET;
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                stop_reg[k] <= (k == 1) ? glm_pkg::STOP1_RESET : '0;
            end
        end
        else if (wr_en)
        begin
            if (wr_index == glm_pkg::REG_COUNT)
            begin
                count_reg <= wr_data[CW-1:0];
            end
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                if (wr_index == glm_pkg::CFG_INDEX_W'(int'(glm_pkg::REG_STOP0) + k))
                begin
                    stop_reg[k] <= wr_data[glm_pkg::STOP_W-1:0];
                end
            end
        end
    end

    assign pos = {level, level};

    always_comb
    begin
        if (count_reg < glm_pkg::COUNT_MIN)
        begin
            n_eff = glm_pkg::COUNT_MIN;
        end
        else if (count_reg > CW'(MAX_STOPS))
        begin
            n_eff = CW'(MAX_STOPS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    always_comb
    begin
        last_pos = '0;
        last_col = '0;
        for (int k = 0; k < MAX_STOPS; k++)
        begin
            p[k]   = stop_reg[k][glm_pkg::STOP_W-1 -: PW];
            col[k] = glm_pkg::rgb_t'(stop_reg[k][glm_pkg::NUM_CH*glm_pkg::CHAN_W-1:0]);
            if (n_eff == CW'(k + 1))
            begin
                last_pos = p[k];
                last_col = col[k];
            end
        end
    end

    // first segment in use that holds the position
    always_comb
    begin
        found  = 1'b0;
        sel_pa = '0;
        sel_pb = '0;
        sel_a  = '0;
        sel_b  = '0;
        for (int k = 0; k < MAX_STOPS - 1; k++)
        begin
            if (!found && (CW'(k + 1) < n_eff) && (pos >= p[k]) && (pos <= p[k+1]))
            begin
                found  = 1'b1;
                sel_pa = p[k];
                sel_pb = p[k+1];
                sel_a  = col[k];
                sel_b  = col[k+1];
            end
        end
    end

    always_comb
    begin
        seg.d    = '0;
        seg.span = '0;
        if (pos <= p[0])
        begin
            seg.ca = col[0];
            seg.cb = col[0];
        end
        else if (pos >= last_pos || !found)
        begin
            seg.ca = last_col;
            seg.cb = last_col;
        end
        else
        begin
            seg.ca   = sel_a;
            seg.cb   = sel_b;
            seg.d    = pos - sel_pa;
            seg.span = sel_pb - sel_pa;
        end
    end

endmodule

>>> hw/rtl/glm_back.sv
// ----------------------------------------------------------------------------
// glm_back
// interpolation pipeline: weighted sum, then one quotient bit per stage
// ----------------------------------------------------------------------------
module glm_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  glm_pkg::seg_t                          seg,
    input  logic                                   seg_valid,
    output logic                                   seg_pop,
    input  logic [$clog2(glm_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                                   res_valid,
    output glm_pkg::rgb_t                          res
);

    localparam int NS    = glm_pkg::BACK_STAGES;
    localparam int DS    = glm_pkg::DIV_STAGES;
    localparam int NC    = glm_pkg::NUM_CH;
    localparam int DW    = glm_pkg::DIVIDEND_W;
    localparam int PRW   = glm_pkg::PROD_W;
    localparam int OCW   = $clog2(glm_pkg::OUT_DEPTH + 1);
    localparam int INF_W = $clog2(NS + 1);
    localparam int SUM_W = ((OCW > INF_W) ? OCW : INF_W) + 1;

    logic [NS-1:0]    v_reg, v_next;
    logic [INF_W-1:0] inflight_reg, inflight_next;
    logic             issue;
    logic             retire;

    glm_pkg::seg_t                          sega_reg;
    logic [NC-1:0][PRW-1:0]                 prod_lo_reg;
    logic [NC-1:0][PRW-1:0]                 prod_hi_reg;
    logic [glm_pkg::POS_W-1:0]              span_b_reg;
    glm_pkg::rgb_t                          ca_b_reg;
    glm_pkg::div_t                          div_reg [DS+1];
    glm_pkg::div_t                          div_first;
    logic [glm_pkg::POS_W-1:0]              rest;

    assign issue  = seg_valid &&
                    ((SUM_W'(out_count) + SUM_W'(inflight_reg)) < SUM_W'(glm_pkg::OUT_DEPTH));
    assign retire = v_reg[NS-1];
    assign seg_pop = issue;

    always_comb
    begin
        v_next        = {v_reg[NS-2:0], issue};
        inflight_next = inflight_reg + INF_W'(issue) - INF_W'(retire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            v_reg        <= v_next;
            inflight_reg <= inflight_next;
        end
    end

    assign rest = sega_reg.span - sega_reg.d;

    always_comb
    begin
        div_first.q    = '0;
        div_first.dvs  = {span_b_reg, 1'b0};
        div_first.ca   = ca_b_reg;
        div_first.zero = (span_b_reg == '0);
        for (int ch = 0; ch < NC; ch++)
        begin
            div_first.rem[ch] = ((DW'(prod_lo_reg[ch]) + DW'(prod_hi_reg[ch])) << 1)
                                + DW'(span_b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            sega_reg <= seg;
        end
        for (int ch = 0; ch < NC; ch++)
        begin
            prod_lo_reg[ch] <= PRW'(sega_reg.ca[ch] * rest);
            prod_hi_reg[ch] <= PRW'(sega_reg.cb[ch] * sega_reg.d);
        end
        span_b_reg <= sega_reg.span;
        ca_b_reg   <= sega_reg.ca;
        div_reg[0] <= div_first;
    end

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        localparam int SH = DS - 1 - k;
        logic [DW-1:0] dsh;
        glm_pkg::div_t div_n;

        assign dsh = DW'(div_reg[k].dvs) << SH;

        always_comb
        begin
            div_n = div_reg[k];
            for (int ch = 0; ch < NC; ch++)
            begin
                if (div_reg[k].rem[ch] >= dsh)
                begin
                    div_n.rem[ch]   = div_reg[k].rem[ch] - dsh;
                    div_n.q[ch][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k+1] <= div_n;
        end
    end

    assign res_valid = retire;
    assign res       = div_reg[DS].zero ? div_reg[DS].ca : div_reg[DS].q;

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INF_W'(NS))
        else $error("in-flight count above pipeline depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_count < OCW'(glm_pkg::OUT_DEPTH)))
        else $error("result word retires into a full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        seg_pop |-> seg_valid)
        else $error("segment queue popped while empty");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == INF_W'($countones(v_reg)))
        else $error("in-flight count out of step with stage valids");

endmodule
